@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Widths, capacity, command and status codes, and the control struct
// that joins the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int TAG_BITS  = 16;
  localparam int PRIO_BITS = 8;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [PRIO_BITS-1:0] prio_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [1:0]           status_t;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input transaction
    logic execute;  // update the slots and load the result register
  } dp_cmd_t;

endpackage

@@ rtl/core/spq_in_if.sv @@
// ----------------------------------------------------------------------------
// spq_in_if: input channel of the stable priority queue
// Valid/ready channel carrying one queue command per transaction.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic            valid;
  logic            ready;
  logic            cmd;
  spq_pkg::tag_t   entry_tag;
  spq_pkg::prio_t  entry_priority;

  modport source (output valid, output cmd, output entry_tag, output entry_priority,
                  input ready);
  modport sink   (input valid, input cmd, input entry_tag, input entry_priority,
                  output ready);
endinterface

@@ rtl/core/spq_out_if.sv @@
// ----------------------------------------------------------------------------
// spq_out_if: result channel of the stable priority queue
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface spq_out_if;
  logic              valid;
  logic              ready;
  spq_pkg::status_t  status;
  spq_pkg::tag_t     out_tag;
  spq_pkg::prio_t    out_priority;
  logic              now_empty;
  logic              now_full;

  modport source (output valid, output status, output out_tag, output out_priority,
                  output now_empty, output now_full, input ready);
  modport sink   (input valid, input status, input out_tag, input out_priority,
                  input now_empty, input now_full, output ready);
endinterface

@@ rtl/core/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl: controller of the stable priority queue
// Two-state sequencer that accepts a command, has the datapath execute it
// and tracks the occupancy of the result register.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::dp_cmd_t  dp_cmd
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  // A new command may enter in the idle state once the result register is free or being drained.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    dp_cmd.capture = 1'b0;
    dp_cmd.execute = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          dp_cmd.capture = 1'b1;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.execute = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath: slot array and result register of the stable priority queue
// Sorted shift-register slots with a parallel compare against the incoming
// priority; inserts in one step, shifts toward the front on removal.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::dp_cmd_t  dp_cmd,
  input  logic              in_cmd,
  input  spq_pkg::tag_t     in_tag,
  input  spq_pkg::prio_t    in_prio,
  output spq_pkg::status_t  res_status,
  output spq_pkg::tag_t     res_tag,
  output spq_pkg::prio_t    res_prio,
  output logic              res_empty,
  output logic              res_full
);
  import spq_pkg::*;

  logic    cmd_r;
  tag_t    tag_in_r;
  prio_t   prio_in_r;

  tag_t    slot_tag_r  [CAPACITY];
  prio_t   slot_prio_r [CAPACITY];
  tag_t    slot_tag_nxt  [CAPACITY];
  prio_t   slot_prio_nxt [CAPACITY];
  count_t  fill_r, fill_nxt;

  logic [CAPACITY-1:0] used;
  logic [CAPACITY-1:0] greater;
  logic                is_full, is_empty;

  status_t res_status_r, res_status_nxt;
  tag_t    res_tag_r, res_tag_nxt;
  prio_t   res_prio_r, res_prio_nxt;
  logic    res_empty_r, res_empty_nxt;
  logic    res_full_r, res_full_nxt;

  assign is_full  = (fill_r == count_t'(CAPACITY));
  assign is_empty = (fill_r == '0);

  // Slots are sorted, so the greater flags form one contiguous run at the back
  // of the occupied part; the new entry lands just ahead of that run.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      used[i]    = count_t'(i) < fill_r;
      greater[i] = used[i] && (slot_prio_r[i] > prio_in_r);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_tag_nxt[i]  = slot_tag_r[i];
      slot_prio_nxt[i] = slot_prio_r[i];
    end
    fill_nxt       = fill_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_prio_nxt   = res_prio_r;
    res_empty_nxt  = res_empty_r;
    res_full_nxt   = res_full_r;

    if (dp_cmd.execute) begin
      res_tag_nxt  = '0;
      res_prio_nxt = '0;
      if (cmd_r == CMD_ENQ) begin
        if (is_full) begin
          res_status_nxt = ST_FULL;
        end else begin
          res_status_nxt = ST_OK;
          fill_nxt       = fill_r + count_t'(1);
          if (greater[0] || !used[0]) begin
            slot_tag_nxt[0]  = tag_in_r;
            slot_prio_nxt[0] = prio_in_r;
          end
          for (int i = 1; i < CAPACITY; i++) begin
            if (greater[i-1]) begin
              slot_tag_nxt[i]  = slot_tag_r[i-1];
              slot_prio_nxt[i] = slot_prio_r[i-1];
            end else if (greater[i] || (count_t'(i) == fill_r)) begin
              slot_tag_nxt[i]  = tag_in_r;
              slot_prio_nxt[i] = prio_in_r;
            end
          end
        end
      end else begin
        if (is_empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          res_status_nxt = ST_OK;
          res_tag_nxt    = slot_tag_r[0];
          res_prio_nxt   = slot_prio_r[0];
          fill_nxt       = fill_r - count_t'(1);
          for (int i = 0; i < CAPACITY - 1; i++) begin
            slot_tag_nxt[i]  = slot_tag_r[i+1];
            slot_prio_nxt[i] = slot_prio_r[i+1];
          end
        end
      end
      res_empty_nxt = (fill_nxt == '0);
      res_full_nxt  = (fill_nxt == count_t'(CAPACITY));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r     <= in_cmd;
      tag_in_r  <= in_tag;
      prio_in_r <= in_prio;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      slot_tag_r[i]  <= slot_tag_nxt[i];
      slot_prio_r[i] <= slot_prio_nxt[i];
    end
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_prio_r   <= res_prio_nxt;
    res_empty_r  <= res_empty_nxt;
    res_full_r   <= res_full_nxt;
  end

  assign res_status = res_status_r;
  assign res_tag    = res_tag_r;
  assign res_prio   = res_prio_r;
  assign res_empty  = res_empty_r;
  assign res_full   = res_full_r;

endmodule

@@ rtl/core/stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded stable priority queue
// Each input transaction enqueues a tagged entry or dequeues the front entry;
// each one yields exactly one result transaction.
//
// Entries with smaller priority values leave first; equal priorities leave in
// arrival order. An enqueue on a full queue is dropped with status full, a
// dequeue on an empty queue returns status empty. Every result carries the
// empty and full flags as they stand after the command.
//
// Timing: a command is executed in the cycle after it is accepted, when the
// sorted slot array is compared in parallel and shifted; the result is
// valid from the cycle after that.
//
// Reset empties the queue. While a result waits for the receiver, one more
// command is not taken until the result register is free or being drained
// in the same cycle.
// ----------------------------------------------------------------------------
module stable_priority_queue (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_chan,
  spq_out_if.source  out_chan
);
  import spq_pkg::*;

  dp_cmd_t  dp_cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .dp_cmd    (dp_cmd)
  );

  spq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .in_cmd     (in_chan.cmd),
    .in_tag     (in_chan.entry_tag),
    .in_prio    (in_chan.entry_priority),
    .res_status (out_chan.status),
    .res_tag    (out_chan.out_tag),
    .res_prio   (out_chan.out_priority),
    .res_empty  (out_chan.now_empty),
    .res_full   (out_chan.now_full)
  );

endmodule
